@@ rtl/pddu_pkg.sv @@
`timescale 1ns / 1ps
// pddu_pkg: constants, codes and the result item type of the pack delta decoder
// no dependencies; imported by pack_delta_instruction_decoder_unit
package pddu_pkg;

   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned LEN_W   = 24;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned ERR_W   = 3;
   localparam int unsigned SHIFT_W = 6;
   localparam int unsigned FLD_W   = 7;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned ADDR_W  = 3;

   // decode phases
   localparam logic [PHASE_W-1:0] PH_SRC   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DST   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_OP    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_COPY  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LIT   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DRAIN = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SRC_SIZE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DST_SIZE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_COPY     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LITERAL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd5;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_BASE      = 3'd1;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd2;
   localparam logic [ERR_W-1:0] ERR_OVERRUN   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_VARINT    = 3'd4;

   // register index
   localparam logic [0:0] REG_BASE_LENGTH = 1'b0;

   localparam logic [SHIFT_W-1:0] VARINT_STEP  = 6'd7;
   localparam logic [SHIFT_W-1:0] VARINT_LAST  = 6'd28;
   localparam logic [LEN_W-1:0]   ZERO_LEN_VAL = 24'h010000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] offset_or_size;
      logic [LEN_W-1:0]  copy_length;
      logic [BYTE_W-1:0] literal;
      logic [SIZE_W-1:0] target_position;
      logic [ERR_W-1:0]  error_code;
      logic              done_res;
   } rsp_item_type;

endpackage

@@ rtl/pack_delta_instruction_decoder_unit.sv @@
`timescale 1ns / 1ps
// pack_delta_instruction_decoder_unit: byte-wise decoder of a binary pack delta
// depends on pddu_pkg
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | delta_byte, final_byte
//  rsp     | out       | rsp_valid/rsp_stall | kind .. done_res, zero or one per item
//  csr     | in/out    | apb, pready high    | base_length at byte address 0
//
// one item per clock while req_stall is low; each byte is decoded combinationally
// from the state registers and captured in the result register on accept
// a skid register holds one result while rsp is stalled; req_stall rises only then
// synchronous reset returns the decoder to the source size and clears base_length
module pack_delta_instruction_decoder_unit
   import pddu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_delta_byte,
   input  logic              req_final_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SIZE_W-1:0] rsp_offset_or_size,
   output logic [LEN_W-1:0]  rsp_copy_length,
   output logic [BYTE_W-1:0] rsp_literal,
   output logic [SIZE_W-1:0] rsp_target_position,
   output logic [ERR_W-1:0]  rsp_error_code,
   output logic              rsp_done_res,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [SIZE_W-1:0]  base_bytes_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [SIZE_W-1:0]  size_acc_ff, size_acc_in;
   logic [FLD_W-1:0]   pending_ff, pending_in;
   logic [SIZE_W-1:0]  copy_off_ff, copy_off_in;
   logic [LEN_W-1:0]   copy_len_ff, copy_len_in;
   logic [FLD_W-1:0]   insert_left_ff, insert_left_in;
   logic [SIZE_W-1:0]  target_size_ff, target_size_in;
   logic [SIZE_W-1:0]  wpos_ff, wpos_in;
   logic               halted_ff, halted_in;

   logic               rsp_valid_ff, skid_valid_ff;
   rsp_item_type       rsp_data_ff, skid_data_ff;

   logic               accept;
   logic               out_free;
   logic               have;
   rsp_item_type       res;

   logic [BYTE_W-1:0]  b;
   logic               fin;
   logic [2:0]         fld;
   logic [FLD_W-1:0]   pend_next;
   logic               do_copy;
   logic [SIZE_W-1:0]  fc_off;
   logic [LEN_W-1:0]   fc_len_acc;
   logic [LEN_W-1:0]   fc_len;
   logic [SIZE_W:0]    base_end;
   logic [SIZE_W:0]    copy_end;
   logic [SIZE_W:0]    ins_end;
   logic [SIZE_W-1:0]  varint_part;

   assign b         = req_delta_byte;
   assign fin       = req_final_byte;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // lowest pending copy field
   always_comb begin
      fld = 3'd6;
      for (int k = 5; k >= 0; k--) begin
         if (pending_ff[k]) begin
            fld = 3'(k);
         end
      end
   end

   assign pend_next   = pending_ff & (pending_ff - 7'd1);
   assign varint_part = {25'd0, b[6:0]} << shift_ff[4:0];
   assign fc_len      = (fc_len_acc == '0) ? ZERO_LEN_VAL : fc_len_acc;
   assign base_end    = {1'b0, fc_off} + {9'd0, fc_len};
   assign copy_end    = {1'b0, wpos_ff} + {9'd0, fc_len};
   assign ins_end     = {1'b0, wpos_ff} + {25'd0, b};

   always_comb begin
      phase_in       = phase_ff;
      shift_in       = shift_ff;
      size_acc_in    = size_acc_ff;
      pending_in     = pending_ff;
      copy_off_in    = copy_off_ff;
      copy_len_in    = copy_len_ff;
      insert_left_in = insert_left_ff;
      target_size_in = target_size_ff;
      wpos_in        = wpos_ff;
      halted_in      = halted_ff;
      have           = 1'b0;
      res            = '0;
      do_copy        = 1'b0;
      fc_off         = copy_off_ff;
      fc_len_acc     = copy_len_ff;

      case (phase_ff)
         PH_SRC, PH_DST: begin
            if (shift_ff >= VARINT_LAST && b[7:4] != 4'd0) begin
               have           = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_VARINT;
               res.done_res   = 1'b1;
            end else begin
               size_acc_in = size_acc_ff | varint_part;
               shift_in    = shift_ff + VARINT_STEP;
               if (!b[7]) begin
                  have               = 1'b1;
                  res.offset_or_size = size_acc_ff | varint_part;
                  size_acc_in        = '0;
                  shift_in           = '0;
                  if (phase_ff == PH_SRC) begin
                     res.kind = KIND_SRC_SIZE;
                     phase_in = PH_DST;
                  end else begin
                     res.kind       = KIND_DST_SIZE;
                     target_size_in = size_acc_ff | varint_part;
                     phase_in       = ((size_acc_ff | varint_part) == '0) ? PH_DRAIN : PH_OP;
                  end
               end
            end
         end
         PH_OP: begin
            if (b[7]) begin
               pending_in  = b[6:0];
               copy_off_in = '0;
               copy_len_in = '0;
               fc_off      = '0;
               fc_len_acc  = '0;
               if (b[6:0] == 7'd0) begin
                  do_copy = 1'b1;
               end else begin
                  phase_in = PH_COPY;
               end
            end else if (b != 8'd0) begin
               if (ins_end > {1'b0, target_size_ff}) begin
                  have           = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_OVERRUN;
                  res.done_res   = 1'b1;
               end else begin
                  insert_left_in = b[6:0];
                  phase_in       = PH_LIT;
               end
            end
         end
         PH_COPY: begin
            case (fld)
               3'd0: fc_off = {copy_off_ff[31:8], copy_off_ff[7:0] | b};
               3'd1: fc_off = {copy_off_ff[31:16], copy_off_ff[15:8] | b, copy_off_ff[7:0]};
               3'd2: fc_off = {copy_off_ff[31:24], copy_off_ff[23:16] | b, copy_off_ff[15:0]};
               3'd3: fc_off = {copy_off_ff[31:24] | b, copy_off_ff[23:0]};
               3'd4: fc_len_acc = {copy_len_ff[23:8], copy_len_ff[7:0] | b};
               3'd5: fc_len_acc = {copy_len_ff[23:16], copy_len_ff[15:8] | b, copy_len_ff[7:0]};
               default: fc_len_acc = {copy_len_ff[23:16] | b, copy_len_ff[15:0]};
            endcase
            copy_off_in = fc_off;
            copy_len_in = fc_len_acc;
            pending_in  = pend_next;
            if (pend_next == '0) begin
               do_copy = 1'b1;
            end
         end
         PH_LIT: begin
            have                = 1'b1;
            res.kind            = KIND_LITERAL;
            res.literal         = b;
            res.target_position = wpos_ff;
            wpos_in             = wpos_ff + 32'd1;
            insert_left_in      = insert_left_ff - 7'd1;
            if (insert_left_ff == 7'd1) begin
               phase_in = ((wpos_ff + 32'd1) == target_size_ff) ? PH_DRAIN : PH_OP;
            end
         end
         default: begin
            if (fin) begin
               have                = 1'b1;
               res.kind            = KIND_END;
               res.offset_or_size  = target_size_ff;
               res.target_position = wpos_ff;
            end
         end
      endcase

      if (do_copy) begin
         have = 1'b1;
         if (base_end > {1'b0, base_bytes_ff}) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_BASE;
            res.done_res   = 1'b1;
         end else if (copy_end > {1'b0, target_size_ff}) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_OVERRUN;
            res.done_res   = 1'b1;
         end else begin
            res.kind            = KIND_COPY;
            res.offset_or_size  = fc_off;
            res.copy_length     = fc_len;
            res.target_position = wpos_ff;
            wpos_in             = copy_end[SIZE_W-1:0];
            phase_in = (copy_end[SIZE_W-1:0] == target_size_ff) ? PH_DRAIN : PH_OP;
         end
      end

      if (halted_ff) begin
         have = 1'b0;
      end else if (have && res.kind == KIND_ERROR) begin
         halted_in = !fin;
      end else if (fin) begin
         if (phase_in == PH_DRAIN && have) begin
            res.done_res = 1'b1;
         end else begin
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
            res.done_res   = 1'b1;
         end
         have = 1'b1;
      end

      // end of delta: back to the start state
      if (fin) begin
         phase_in       = PH_SRC;
         shift_in       = '0;
         size_acc_in    = '0;
         pending_in     = '0;
         copy_off_in    = '0;
         copy_len_in    = '0;
         insert_left_in = '0;
         target_size_in = '0;
         wpos_in        = '0;
         halted_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SRC;
         shift_ff       <= '0;
         size_acc_ff    <= '0;
         pending_ff     <= '0;
         copy_off_ff    <= '0;
         copy_len_ff    <= '0;
         insert_left_ff <= '0;
         target_size_ff <= '0;
         wpos_ff        <= '0;
         halted_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         shift_ff       <= shift_in;
         size_acc_ff    <= size_acc_in;
         pending_ff     <= pending_in;
         copy_off_ff    <= copy_off_in;
         copy_len_ff    <= copy_len_in;
         insert_left_ff <= insert_left_in;
         target_size_ff <= target_size_in;
         wpos_ff        <= wpos_in;
         halted_ff      <= halted_in;
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && have) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept && have) begin
         if (out_free) begin
            rsp_data_ff <= res;
         end else begin
            skid_data_ff <= res;
         end
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         base_bytes_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == REG_BASE_LENGTH) begin
         base_bytes_ff <= csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BASE_LENGTH) ? base_bytes_ff : 32'd0;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_data_ff.kind;
   assign rsp_offset_or_size  = rsp_data_ff.offset_or_size;
   assign rsp_copy_length     = rsp_data_ff.copy_length;
   assign rsp_literal         = rsp_data_ff.literal;
   assign rsp_target_position = rsp_data_ff.target_position;
   assign rsp_error_code      = rsp_data_ff.error_code;
   assign rsp_done_res        = rsp_data_ff.done_res;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_ERROR |-> rsp_data_ff.done_res)
      else $error("error item without done flag");

   a_wpos_in_target: assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= target_size_ff)
      else $error("write position beyond target size");

   a_final_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && req_final_byte |=> phase_ff == PH_SRC && !halted_ff && wpos_ff == '0)
      else $error("decoder not back at start after final byte");

endmodule
